// ===== design/sensor_frame_crc_checker_assert.svh =====
// assertion macros shared by the sensor frame crc checker rtl
`ifndef SENSOR_FRAME_CRC_CHECKER_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECKER_ASSERT_SVH

// clocked assertion, masked while reset is applied
`define SFCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion, checked during reset as well
`define SFCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/sfcc_pkg.sv =====
// types, constants and crc byte update for the sensor frame crc checker
`default_nettype none

package sfcc_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [2:0]  CRC_BYTES  = 3'd6;
  localparam logic [2:0]  POS_HUM_HI = 3'd2;
  localparam logic [2:0]  POS_HUM_LO = 3'd3;
  localparam logic [2:0]  POS_TMP_HI = 3'd4;
  localparam logic [2:0]  POS_TMP_LO = 3'd5;
  localparam logic [2:0]  POS_CRC_LO = 3'd6;
  localparam logic [2:0]  FRAME_LAST = 3'd7;

  typedef logic [2:0] byte_pos_t;

  // crc-16/modbus over one byte, eight reflected shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sensor_frame_crc_checker.sv =====
// sensor frame crc checker: crc-16/modbus check of an 8-byte sensor frame
//
//   channel | dir | tdata                          | tuser
//   --------+-----+--------------------------------+-------------
//   in_     | in  | [7:0] rx_byte                  | frame_start
//   out_    | out | [15:0] humidity, [31:16] temp  | crc_ok
//
// one byte is taken per cycle while in_tready is high; the eighth frame byte
// passes the input register, then the result register, to give the result.
// the crc byte update is an unrolled, combinational eight-step shift network.
// reset: rst_n synchronous, active low; position 0, crc 0xffff, no result held.
// stalls: a held result only blocks input when the registered byte is the last
// of a frame, so in_tready then follows out_tready in the same cycle.
`default_nettype none

module sensor_frame_crc_checker
  import sfcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] humidity_tenths, [31:16] temperature_tenths
  output logic             out_tuser   // [0] crc_ok
);

  `include "sensor_frame_crc_checker_assert.svh"

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;

  // frame state
  byte_pos_t   pos_r;
  logic [15:0] crc_r;
  logic [15:0] hum_r;
  logic [15:0] tmp_r;
  logic [7:0]  rxlo_r;

  // result register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_ok_r;

  byte_pos_t   pos_eff;
  logic [15:0] crc_base;
  logic        is_last;
  logic        s1_fire;
  logic        in_fire;
  logic        out_load;
  logic [15:0] crc_nxt;

  // position and crc seen by the registered byte, a start marker restarts both
  always_comb begin
    pos_eff  = s1_start_r ? '0 : pos_r;
    crc_base = s1_start_r ? CRC_INIT : crc_r;
    is_last  = (pos_eff == FRAME_LAST);
    crc_nxt  = (pos_eff < CRC_BYTES) ? crc_byte(crc_base, s1_byte_r) : crc_base;
  end

  // handshake between the stages
  assign s1_fire   = s1_valid_r && (!is_last || !out_valid_r || out_tready);
  assign out_load  = s1_fire && is_last;
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // frame state update on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= CRC_INIT;
      hum_r  <= '0;
      tmp_r  <= '0;
      rxlo_r <= '0;
    end else if (s1_fire) begin
      case (pos_eff)
        POS_HUM_HI: hum_r[15:8] <= s1_byte_r;
        POS_HUM_LO: hum_r[7:0]  <= s1_byte_r;
        POS_TMP_HI: tmp_r[15:8] <= s1_byte_r;
        POS_TMP_LO: tmp_r[7:0]  <= s1_byte_r;
        POS_CRC_LO: rxlo_r      <= s1_byte_r;
        default: ;
      endcase
      if (is_last) begin
        pos_r <= '0;
        crc_r <= CRC_INIT;
      end else begin
        pos_r <= pos_eff + 3'd1;
        crc_r <= crc_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_ok_r   <= (crc_base == {s1_byte_r, rxlo_r});
      out_data_r <= {tmp_r, hum_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  // checks
  `SFCC_ASSERT(a_frame_end_restarts, out_load |=> (pos_r == '0) && (crc_r == CRC_INIT), "frame end must restart position and crc")
  `SFCC_ASSERT(a_no_result_overwrite, out_load |-> (!out_valid_r || out_tready), "pending result overwritten")
  `SFCC_ASSERT(a_start_gives_pos_one, (s1_fire && s1_start_r) |=> (pos_r == 3'd1), "start byte must leave position one")
  `SFCC_ASSERT_ALWAYS(a_stall_needs_byte, (rst_n && !in_tready) |-> s1_valid_r, "input stalled with empty input register")

endmodule

`default_nettype wire
